FILE: rtl/gbn_pkg.sv
// ---------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the Go-Back-N sender window.
// ---------------------------------------------------------------------------
package gbn_pkg;

	localparam int SEQ_W     = 4;
	localparam int SEQ_SPACE = 16;
	localparam int HANDLE_W  = 16;
	localparam int LEN_W     = 9;
	localparam int ENTRY_W   = HANDLE_W + LEN_W;

	localparam logic [LEN_W-1:0] MAX_PAYLOAD  = 9'd256;
	localparam logic [SEQ_W-1:0] WINDOW_RESET = 4'd4;

	// operation codes
	localparam logic [1:0] OP_OFFER   = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [HANDLE_W-1:0] payload_handle;
		logic [LEN_W-1:0]    payload_length;
		logic [SEQ_W-1:0]    ack_seq;
		logic                ack_ok;
	} item_t;

	typedef struct packed {
		logic                accepted;
		logic                send_valid;
		logic [SEQ_W-1:0]    send_seq;
		logic [HANDLE_W-1:0] send_handle;
		logic [LEN_W-1:0]    send_length;
		logic                timer_start;
		logic                timer_stop;
		logic                ack_taken;
		logic                all_acked;
		logic                last;
	} result_t;

endpackage

FILE: rtl/gbn_item_if.sv
// ---------------------------------------------------------------------------
// gbn_item_if
// Valid/ready channel carrying one input item.
// ---------------------------------------------------------------------------
interface gbn_item_if;
	logic           valid;
	logic           ready;
	gbn_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gbn_result_if.sv
// ---------------------------------------------------------------------------
// gbn_result_if
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface gbn_result_if;
	logic             valid;
	logic             ready;
	gbn_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gbn_ram.sv
// ---------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM; read data registered, held
// while no read is issued.
// ---------------------------------------------------------------------------
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/go_back_n_sender_window.sv
// ---------------------------------------------------------------------------
// go_back_n_sender_window
// Sender side of Go-Back-N with 4-bit sequence numbers.
// ---------------------------------------------------------------------------
// An offer, an ACK, or a timeout with nothing outstanding yields one result,
// registered in the output register; the input is ready again as soon as
// that register is free or being emptied.
// A timeout with n packets outstanding reads the descriptor store once per
// packet through its single read port: the first read is issued on the
// accepting edge, then one result a cycle while the output slot is free;
// the input is not ready until the last packet is resent. Descriptor entries are only
// ever read for outstanding packets, each written when it was first sent,
// so the store needs no clearing after reset. window_size may be written
// at any time the block is idle; values 1..15 are meaningful, 0 refuses all
// offers and ACKs.
// ---------------------------------------------------------------------------
module go_back_n_sender_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [gbn_pkg::SEQ_W-1:0]  cfg_wdata,
	gbn_item_if.sink                   item,
	gbn_result_if.source               result
);

	// control registers
	gbn_pkg::state_t             st_q, st_d;
	logic [gbn_pkg::SEQ_W-1:0]   window_q;
	logic [gbn_pkg::SEQ_W-1:0]   base_q, base_d;
	logic [gbn_pkg::SEQ_W-1:0]   next_q, next_d;
	logic [gbn_pkg::SEQ_W-1:0]   seq_q, seq_d;     // resend cursor
	logic                        first_q, first_d; // first resend of a timeout
	logic                        out_valid_q;
	gbn_pkg::result_t            out_q;

	// working signals
	gbn_pkg::result_t            res;
	logic                        load;
	logic                        slot_free;
	logic                        accept;
	logic [gbn_pkg::SEQ_W-1:0]   outstanding;
	logic [gbn_pkg::SEQ_W-1:0]   ack_dist;
	logic [gbn_pkg::SEQ_W-1:0]   ack_next;
	logic [gbn_pkg::SEQ_W-1:0]   ack_left;
	logic [gbn_pkg::SEQ_W-1:0]   seq_inc;
	logic                        offer_take;
	logic                        ack_take;

	// store ports
	logic                          st_we;
	logic                          st_re;
	logic [gbn_pkg::SEQ_W-1:0]     st_raddr;
	logic [gbn_pkg::ENTRY_W-1:0]   st_wdata;
	logic [gbn_pkg::ENTRY_W-1:0]   st_rdata;

	gbn_ram #(
		.WIDTH (gbn_pkg::ENTRY_W),
		.DEPTH (gbn_pkg::SEQ_SPACE)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (next_q),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// output slot is free when empty or when its transfer completes now
	assign slot_free    = !out_valid_q || result.ready;
	assign item.ready   = (st_q == gbn_pkg::ST_IDLE) && slot_free;
	assign accept       = item.valid && item.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// window arithmetic, all mod 16 by natural wrap
	assign outstanding = next_q - base_q;
	assign ack_dist    = item.data.ack_seq - base_q;
	assign ack_next    = item.data.ack_seq + gbn_pkg::SEQ_W'(1);
	assign ack_left    = next_q - ack_next;
	assign seq_inc     = seq_q + gbn_pkg::SEQ_W'(1);

	assign offer_take = (item.data.payload_length != '0)
		&& (item.data.payload_length <= gbn_pkg::MAX_PAYLOAD)
		&& (outstanding < window_q);
	assign ack_take = item.data.ack_ok && (ack_dist < window_q)
		&& (ack_dist < outstanding);

	assign st_wdata = {item.data.payload_handle, item.data.payload_length};

	always_comb begin
		res      = '0;
		load     = 1'b0;
		st_d     = st_q;
		base_d   = base_q;
		next_d   = next_q;
		seq_d    = seq_q;
		first_d  = first_q;
		st_we    = 1'b0;
		st_re    = 1'b0;
		st_raddr = seq_q;

		case (st_q)
			gbn_pkg::ST_IDLE: begin
				if (accept) begin
					load          = 1'b1;
					res.last      = 1'b1;
					res.all_acked = (outstanding == '0);
					case (item.data.operation)
						gbn_pkg::OP_OFFER: begin
							if (offer_take) begin
								st_we           = 1'b1;
								res.accepted    = 1'b1;
								res.send_valid  = 1'b1;
								res.send_seq    = next_q;
								res.send_handle = item.data.payload_handle;
								res.send_length = item.data.payload_length;
								res.timer_start = (outstanding == '0);
								res.all_acked   = 1'b0;
								next_d          = next_q + gbn_pkg::SEQ_W'(1);
							end
						end
						gbn_pkg::OP_ACK: begin
							if (ack_take) begin
								base_d         = ack_next;
								res.ack_taken  = 1'b1;
								res.all_acked  = (ack_left == '0);
								res.timer_stop = (ack_left == '0);
							end
						end
						gbn_pkg::OP_TIMEOUT: begin
							if (outstanding == '0) begin
								res.timer_start = 1'b1;
							end else begin
								// start the resend walk at the base
								load     = 1'b0;
								st_re    = 1'b1;
								st_raddr = base_q;
								seq_d    = base_q;
								first_d  = 1'b1;
								st_d     = gbn_pkg::ST_SEND;
							end
						end
						default: ; // unused code: plain status result
					endcase
				end
			end
			gbn_pkg::ST_SEND: begin
				// store data for seq_q is valid; fetch the next while emitting
				if (slot_free) begin
					load            = 1'b1;
					res.send_valid  = 1'b1;
					res.send_seq    = seq_q;
					res.send_handle = st_rdata[gbn_pkg::ENTRY_W-1:gbn_pkg::LEN_W];
					res.send_length = st_rdata[gbn_pkg::LEN_W-1:0];
					res.timer_start = first_q;
					res.last        = (seq_inc == next_q);
					first_d         = 1'b0;
					if (seq_inc == next_q) begin
						st_d = gbn_pkg::ST_IDLE;
					end else begin
						st_re    = 1'b1;
						st_raddr = seq_inc;
						seq_d    = seq_inc;
					end
				end
			end
			default: st_d = gbn_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= gbn_pkg::ST_IDLE;
			window_q    <= gbn_pkg::WINDOW_RESET;
			base_q      <= '0;
			next_q      <= '0;
			seq_q       <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			base_q  <= base_d;
			next_q  <= next_d;
			seq_q   <= seq_d;
			first_q <= first_d;
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

endmodule
